@@ src/rau_pkg.sv @@
// Package: shared types, codes and widths for the rational arithmetic unit.
package rau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W = 64;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_LESS    = 3'd4,
        OP_GREATER = 3'd5,
        OP_EQUAL   = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] a_numerator;
        logic signed [31:0] a_denominator;
        logic signed [31:0] b_numerator;
        logic signed [31:0] b_denominator;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_numerator;
        logic [30:0]        result_denominator;
        logic               compare_true;
        logic [1:0]         status;
    } out_word_t;

    // Datapath micro-commands issued by the controller.
    typedef enum logic [3:0] {
        DC_NOP,
        DC_LOAD,       // capture input, set up reduction of a
        DC_RED_STEP,   // one Euclid or quotient step
        DC_SAVE_A,     // store reduced a, set up reduction of b
        DC_SAVE_B,     // store reduced b
        DC_MUL1,       // p = a.num*b.den
        DC_MUL2,       // q = b.num*a.den
        DC_MUL3,       // an*bn
        DC_MUL4,       // ad*bd
        DC_FORM,       // form result num/den, set up reduction
        DC_FINISH      // check bounds, build output word
    } dcmd_t;

    typedef struct packed {
        logic red_done;
        logic zero_den;
        logic is_cmp;
        logic div_zero;
        logic no_op;
    } dstat_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RED_A, S_SAVE_A, S_RED_B, S_SAVE_B,
        S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_FORM, S_RED_R, S_FINISH
    } state_t;

endpackage

@@ src/rau_divider.sv @@
// Restoring divider: one quotient bit per cycle on 64-bit unsigned values.
module rau_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [rau_pkg::MAG_W-1:0] dividend,
    input  logic [rau_pkg::MAG_W-1:0] divisor,
    output logic                  done,
    output logic [rau_pkg::MAG_W-1:0] quotient,
    output logic [rau_pkg::MAG_W-1:0] remainder
);
    import rau_pkg::*;

    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   shifted;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        shifted  = {rem_reg, quo_reg[MAG_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = 7'(MAG_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[MAG_W])
            begin
                rem_next = trial[MAG_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[MAG_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // The last bit is formed in the done cycle, so hand out the next values.
    assign done      = run_reg && (cnt_reg == 7'd1);
    assign quotient  = quo_next;
    assign remainder = rem_next;
endmodule

@@ src/rau_datapath.sv @@
// Datapath: operand registers, 32x32 multiplier, Euclid reduction over the divider.
module rau_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::dcmd_t     cmd,
    input  rau_pkg::in_word_t  in_word,
    output rau_pkg::dstat_t    stat,
    output rau_pkg::out_word_t out_word
);
    import rau_pkg::*;

    localparam logic [MAG_W-1:0] LIM = MAG_W'(64'd1) << (VALUE_WIDTH - 1);

    // Reduction sub-phases.
    typedef enum logic [2:0] {
        R_GCD_GO, R_GCD_WAIT, R_QN_GO, R_QN_WAIT, R_QD_GO, R_QD_WAIT, R_DONE
    } rphase_t;

    logic [2:0]       op_reg;
    logic             zd_reg;
    logic             an_neg_reg, bn_neg_reg;
    logic [31:0]      an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic [MAG_W-1:0] p_reg, q_reg, mm_reg, dd_reg;
    // working fraction under reduction
    logic             w_neg_reg, w_neg_next;
    logic [MAG_W-1:0] w_num_reg, w_num_next, w_den_reg, w_den_next;
    logic [MAG_W-1:0] gx_reg, gx_next, gy_reg, gy_next;
    rphase_t          ph_reg, ph_next;
    out_word_t        ow_reg, ow_next;

    logic             dv_start;
    logic [MAG_W-1:0] dv_a, dv_b, dv_q, dv_r;
    logic             dv_done;

    logic [31:0]      mul_x, mul_y;
    logic [MAG_W-1:0] mul_p;

    logic             pn, qn, sn;
    logic [MAG_W-1:0] sm;
    logic             num_ok;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    rau_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (dv_a),
        .divisor   (dv_b),
        .done      (dv_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    always_comb
    begin
        unique case (cmd)
            DC_MUL1: begin mul_x = an_m_reg; mul_y = bd_m_reg; end
            DC_MUL2: begin mul_x = bn_m_reg; mul_y = ad_m_reg; end
            DC_MUL3: begin mul_x = an_m_reg; mul_y = bn_m_reg; end
            default: begin mul_x = ad_m_reg; mul_y = bd_m_reg; end
        endcase
        mul_p = {32'd0, mul_x} * {32'd0, mul_y};
    end

    always_comb
    begin
        pn = (p_reg != '0) && an_neg_reg;
        qn = (op_reg == OP_SUB) ? !bn_neg_reg : bn_neg_reg;
        if (q_reg == '0)
            qn = 1'b0;
        if (pn == qn)
        begin
            sn = pn;
            sm = p_reg + q_reg;
        end
        else if (p_reg >= q_reg)
        begin
            sn = pn;
            sm = p_reg - q_reg;
        end
        else
        begin
            sn = qn;
            sm = q_reg - p_reg;
        end
    end

    // Reduction engine: Euclid on (gx, gy), then num/g and den/g.
    always_comb
    begin
        ph_next    = ph_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        w_num_next = w_num_reg;
        w_den_next = w_den_reg;
        w_neg_next = w_neg_reg;
        dv_start   = 1'b0;
        dv_a       = gx_reg;
        dv_b       = gy_reg;
        if (cmd == DC_RED_STEP)
        begin
            unique case (ph_reg)
                R_GCD_GO:
                begin
                    if (gy_reg == '0)
                        ph_next = R_QN_GO;
                    else
                    begin
                        dv_start = 1'b1;
                        ph_next  = R_GCD_WAIT;
                    end
                end
                R_GCD_WAIT:
                begin
                    if (dv_done)
                    begin
                        gx_next = gy_reg;
                        gy_next = dv_r;
                        ph_next = R_GCD_GO;
                    end
                end
                R_QN_GO:
                begin
                    dv_a     = w_num_reg;
                    dv_b     = gx_reg;
                    dv_start = 1'b1;
                    ph_next  = R_QN_WAIT;
                end
                R_QN_WAIT:
                begin
                    if (dv_done)
                    begin
                        w_num_next = dv_q;
                        ph_next    = R_QD_GO;
                    end
                end
                R_QD_GO:
                begin
                    dv_a     = w_den_reg;
                    dv_b     = gx_reg;
                    dv_start = 1'b1;
                    ph_next  = R_QD_WAIT;
                end
                R_QD_WAIT:
                begin
                    if (dv_done)
                    begin
                        w_den_next = dv_q;
                        ph_next    = R_DONE;
                    end
                end
                default: ph_next = R_DONE;
            endcase
        end
        else if (cmd == DC_LOAD || cmd == DC_SAVE_A || cmd == DC_FORM)
        begin
            // set up a new reduction
            unique case (cmd)
                DC_LOAD:
                begin
                    w_neg_next = in_word.a_numerator[31] != in_word.a_denominator[31];
                    w_num_next = {32'd0, mag32(in_word.a_numerator)};
                    w_den_next = {32'd0, mag32(in_word.a_denominator)};
                end
                DC_SAVE_A:
                begin
                    w_neg_next = bn_neg_reg;
                    w_num_next = {32'd0, bn_m_reg};
                    w_den_next = {32'd0, bd_m_reg};
                end
                default:
                begin
                    if (op_reg == OP_MUL)
                    begin
                        w_neg_next = an_neg_reg != bn_neg_reg;
                        w_num_next = mm_reg;
                        w_den_next = dd_reg;
                    end
                    else if (op_reg == OP_DIV)
                    begin
                        w_neg_next = an_neg_reg != bn_neg_reg;
                        w_num_next = p_reg;
                        w_den_next = q_reg;
                    end
                    else
                    begin
                        w_neg_next = sn;
                        w_num_next = sm;
                        w_den_next = dd_reg;
                    end
                end
            endcase
            gx_next = w_num_next;
            gy_next = w_den_next;
            if (w_num_next == '0)
            begin
                // zero becomes 0/1
                w_neg_next = 1'b0;
                w_den_next = MAG_W'(1);
                ph_next    = R_DONE;
            end
            else
                ph_next = R_GCD_GO;
        end
    end

    always_comb
    begin
        ow_next = ow_reg;
        num_ok  = w_neg_reg ? (w_num_reg <= LIM) : (w_num_reg < LIM);
        if (cmd == DC_FINISH)
        begin
            ow_next.result_numerator   = '0;
            ow_next.result_denominator = 31'd1;
            ow_next.compare_true       = 1'b0;
            ow_next.status             = ST_OK;
            if (zd_reg)
                ow_next.status = ST_ZERO_DEN;
            else if (op_reg == OP_NONE)
                ow_next.status = ST_OK;
            else if (op_reg == OP_LESS || op_reg == OP_GREATER || op_reg == OP_EQUAL)
            begin
                logic c_lt, c_gt, ap, bp;
                ap = an_neg_reg && (p_reg != '0);
                bp = bn_neg_reg && (q_reg != '0);
                if (ap != bp)
                begin
                    c_lt = ap;
                    c_gt = !ap;
                end
                else if (p_reg == q_reg)
                begin
                    c_lt = 1'b0;
                    c_gt = 1'b0;
                end
                else
                begin
                    c_lt = (p_reg < q_reg) != ap;
                    c_gt = !c_lt;
                end
                unique case (op_reg)
                    OP_LESS:    ow_next.compare_true = c_lt;
                    OP_GREATER: ow_next.compare_true = c_gt;
                    default:    ow_next.compare_true = (an_neg_reg == bn_neg_reg)
                                    && (an_m_reg == bn_m_reg) && (ad_m_reg == bd_m_reg);
                endcase
            end
            else if (op_reg == OP_DIV && bn_m_reg == '0)
                ow_next.status = ST_DIV_ZERO;
            else if (!num_ok || w_den_reg >= LIM)
                ow_next.status = ST_OVERFLOW;
            else
            begin
                ow_next.result_numerator   = w_neg_reg ? (32'd0 - w_num_reg[31:0])
                                                       : w_num_reg[31:0];
                ow_next.result_denominator = w_den_reg[30:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= R_DONE;
        else
            ph_reg <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        w_num_reg <= w_num_next;
        w_den_reg <= w_den_next;
        w_neg_reg <= w_neg_next;
        ow_reg    <= ow_next;
        unique case (cmd)
            DC_LOAD:
            begin
                op_reg     <= in_word.operation;
                zd_reg     <= (in_word.a_denominator == '0) || (in_word.b_denominator == '0);
                bn_neg_reg <= in_word.b_numerator[31] != in_word.b_denominator[31];
                bn_m_reg   <= mag32(in_word.b_numerator);
                bd_m_reg   <= mag32(in_word.b_denominator);
            end
            DC_SAVE_A:
            begin
                an_neg_reg <= w_neg_reg;
                an_m_reg   <= w_num_reg[31:0];
                ad_m_reg   <= w_den_reg[31:0];
            end
            DC_SAVE_B:
            begin
                bn_neg_reg <= w_neg_reg;
                bn_m_reg   <= w_num_reg[31:0];
                bd_m_reg   <= w_den_reg[31:0];
            end
            DC_MUL1: p_reg  <= mul_p;
            DC_MUL2: q_reg  <= mul_p;
            DC_MUL3: mm_reg <= mul_p;
            DC_MUL4: dd_reg <= mul_p;
            default: ;
        endcase
    end

    assign stat.red_done = (ph_reg == R_DONE);
    assign stat.zero_den = zd_reg;
    assign stat.is_cmp   = op_reg[2];
    assign stat.div_zero = (op_reg == OP_DIV) && (bn_m_reg == '0);
    assign stat.no_op    = (op_reg == OP_NONE);
    assign out_word      = ow_reg;
endmodule

@@ src/rau_controller.sv @@
// Controller: sequences reductions, products and the final result build.
module rau_controller
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rau_pkg::dstat_t stat,
    output rau_pkg::dcmd_t  cmd,
    output logic            busy,
    output logic            done
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = DC_NOP;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = DC_LOAD;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
                state_next = stat.zero_den || stat.no_op ? S_FINISH : S_RED_A;
            S_RED_A:
            begin
                cmd = DC_RED_STEP;
                if (stat.red_done)
                begin
                    cmd        = DC_SAVE_A;
                    state_next = S_SAVE_A;
                end
            end
            S_SAVE_A: begin cmd = DC_RED_STEP; state_next = S_RED_B; end
            S_RED_B:
            begin
                cmd = DC_RED_STEP;
                if (stat.red_done)
                begin
                    cmd        = DC_SAVE_B;
                    state_next = S_SAVE_B;
                end
            end
            S_SAVE_B: begin cmd = DC_MUL1; state_next = S_MUL1; end
            S_MUL1:   begin cmd = DC_MUL2; state_next = S_MUL2; end
            S_MUL2:
            begin
                if (stat.is_cmp || stat.div_zero)
                begin
                    cmd        = DC_FINISH;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = DC_MUL3;
                    state_next = S_MUL3;
                end
            end
            S_MUL3: begin cmd = DC_MUL4; state_next = S_MUL4; end
            S_MUL4: begin cmd = DC_FORM; state_next = S_FORM; end
            S_FORM: begin cmd = DC_RED_STEP; state_next = S_RED_R; end
            S_RED_R:
            begin
                cmd = DC_RED_STEP;
                if (stat.red_done)
                begin
                    cmd        = DC_FINISH;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.zero_den || stat.no_op)
                    cmd = DC_FINISH;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The finishing command is issued on entry to S_FINISH except on the
    // short path, where it is issued in S_FINISH; done is registered and follows in the next cycle.
    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
endmodule

@@ src/rational_arithmetic_unit_core.sv @@
// Top level: rational arithmetic unit with GCD reduction.
// Usage: raise start with a word on in_word while busy is low; the word is
// taken at that edge and busy rises. One result word appears on out_word,
// marked by done for exactly one cycle; the receiver cannot stall, so capture it
// then. Unless a denominator is zero or the operation is OP_NONE, each item
// takes one Euclid reduction per operand, and an arithmetic result that is formed
// takes one more; each is built from restoring divisions of 64-bit values
// through a single shared divider: one division per Euclid step plus two
// quotient divisions per reduction. Products use one 32x32 multiplier, for up
// to four products (DC_MUL1 to DC_MUL4). Nothing is kept between items.
module rational_arithmetic_unit_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rau_pkg::in_word_t  in_word,
    output logic               busy,
    output logic               done,
    output rau_pkg::out_word_t out_word
);
    import rau_pkg::*;

    dcmd_t  cmd;
    dstat_t stat;

    rau_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    rau_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (in_word),
        .stat     (stat),
        .out_word (out_word)
    );
endmodule

@@ bench/tb_rational_arithmetic_unit_core.sv @@
// Testbench: checks the rational arithmetic unit against an exact fraction predictor.
module tb_rational_arithmetic_unit_core;

    import rau_pkg::*;

    // Hold the expected result words and compare each finished word with the oldest.
    class fraction_scoreboard;
        out_word_t pending[$];
        int        errors;

        function new();
            pending = {};
            errors  = 0;
        endfunction

        // Euclid on magnitudes.
        function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
            logic [63:0] r;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        // Reduce a sign-magnitude fraction; zero becomes 0/1.
        function automatic void reduce(inout logic neg, inout logic [63:0] num,
                                       inout logic [63:0] den);
            logic [63:0] g;
            if (num == 0)
            begin
                neg = 1'b0;
                den = 64'd1;
            end
            else
            begin
                g   = gcd64(num, den);
                num = num / g;
                den = den / g;
            end
        endfunction

        function automatic logic [63:0] magnitude(logic [31:0] v);
            return v[31] ? {32'd0, -v} : {32'd0, v};
        endfunction

        // Work out the answer for one accepted input word.
        function automatic out_word_t predict_result(in_word_t w);
            out_word_t   o;
            logic        an, bn, rn, pn, qn;
            logic [63:0] anm, adm, bnm, bdm, p, q, rm, rd, lim;
            op_t         op;
            o = '{result_numerator: 32'sd0, result_denominator: 31'd1,
                  compare_true: 1'b0, status: ST_OK};
            op = op_t'(w.operation);
            if (w.a_denominator == 0 || w.b_denominator == 0)
            begin
                o.status = ST_ZERO_DEN;
                return o;
            end
            if (op == OP_NONE)
                return o;
            an  = w.a_numerator[31] ^ w.a_denominator[31];
            anm = magnitude(w.a_numerator);
            adm = magnitude(w.a_denominator);
            reduce(an, anm, adm);
            bn  = w.b_numerator[31] ^ w.b_denominator[31];
            bnm = magnitude(w.b_numerator);
            bdm = magnitude(w.b_denominator);
            reduce(bn, bnm, bdm);
            p = anm * bdm;
            q = bnm * adm;
            if (op inside {OP_LESS, OP_GREATER, OP_EQUAL})
            begin
                // Signs are already cleared for zero values.
                case (op)
                    OP_LESS:    o.compare_true = (an != bn) ? an : (an ? p > q : p < q);
                    OP_GREATER: o.compare_true = (an != bn) ? bn : (an ? p < q : p > q);
                    default:    o.compare_true = (an == bn) && (p == q);
                endcase
                return o;
            end
            if (op == OP_DIV && bnm == 0)
            begin
                o.status = ST_DIV_ZERO;
                return o;
            end
            case (op)
                OP_MUL:
                begin
                    rn = an ^ bn; rm = anm * bnm; rd = adm * bdm;
                end
                OP_DIV:
                begin
                    rn = an ^ bn; rm = p; rd = q;
                end
                default:
                begin
                    pn = an;
                    qn = (op == OP_SUB) ? ~bn : bn;
                    if (q == 0) qn = 1'b0;
                    if (pn == qn)
                    begin
                        rn = pn; rm = p + q;
                    end
                    else if (p >= q)
                    begin
                        rn = pn; rm = p - q;
                    end
                    else
                    begin
                        rn = qn; rm = q - p;
                    end
                    rd = adm * bdm;
                end
            endcase
            reduce(rn, rm, rd);
            lim = 64'd1 << (VALUE_WIDTH - 1);
            if ((rn ? rm > lim : rm >= lim) || rd >= lim)
                o.status = ST_OVERFLOW;
            else
            begin
                o.result_numerator   = rn ? -rm[31:0] : rm[31:0];
                o.result_denominator = rd[30:0];
            end
            return o;
        endfunction

        function void note_input(in_word_t w);
            pending.push_back(predict_result(w));
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.result_numerator !== want.result_numerator)
            begin
                $display("%0t: numerator expected %0d actual %0d", $time,
                         want.result_numerator, got.result_numerator);
                errors++;
            end
            if (got.result_denominator !== want.result_denominator)
            begin
                $display("%0t: denominator expected %0d actual %0d", $time,
                         want.result_denominator, got.result_denominator);
                errors++;
            end
            if (got.compare_true !== want.compare_true)
            begin
                $display("%0t: compare expected %0b actual %0b", $time,
                         want.compare_true, got.compare_true);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    // Long Euclid chains make some words slow to finish.
    localparam int STALL_LIMIT  = 50000;
    localparam int RANDOM_WORDS = 1950;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  in_word;
    logic      busy;
    logic      done;
    out_word_t out_word;

    fraction_scoreboard board;
    int                 idle_cycles;

    rational_arithmetic_unit_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_word  (in_word),
        .busy     (busy),
        .done     (done),
        .out_word (out_word)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every finished word at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(out_word);
    end

    // Watchdog: count cycles in which no word is accepted and none finishes.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one word after a random gap; hold start until it is taken.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        in_word = w;
        start   = 1'b1;
        do
            @(posedge clk);
        while (busy);
        board.note_input(w);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic send_fields(input op_t op, input logic [31:0] an,
                               input logic [31:0] ad, input logic [31:0] bn,
                               input logic [31:0] bd);
        in_word_t w;
        w.operation     = op;
        w.a_numerator   = an;
        w.a_denominator = ad;
        w.b_numerator   = bn;
        w.b_denominator = bd;
        send_word(w);
    endtask

    // Draw a field: mostly small values, some extremes, some fully random.
    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'd0;
            3, 4:    return $urandom;
            5:       return $urandom_range(0, 65535) - 32768;
            default: return $urandom_range(0, 200) - 100;
        endcase
    endfunction

    initial
    begin
        in_word_t w;
        logic [31:0] n;
        int k;
        board       = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        in_word     = '0;
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every operation on plain values, then the corner cases.
        for (k = 0; k < 8; k++)
            send_fields(op_t'(k), 32'd3, 32'd4, -32'sd5, 32'd6);
        send_fields(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);          // zero denominator, left
        send_fields(OP_LESS, 32'd1, 32'd2, 32'd1, 32'd0);         // zero denominator, compare
        send_fields(OP_DIV, 32'd1, 32'd2, 32'd0, -32'sd7);        // division by zero
        send_fields(OP_MUL, 32'h7fff_ffff, 32'd1, 32'd2, 32'd1);  // overflow
        send_fields(OP_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd5);  // most negative fits
        send_fields(OP_SUB, 32'd0, 32'd1, 32'h8000_0000, 32'd1);  // negation overflows
        send_fields(OP_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'd1);  // operand out of range
        send_fields(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_fields(OP_EQUAL, 32'd2, 32'd4, -32'sd3, -32'sd6);
        send_fields(OP_GREATER, -32'sd1, 32'd3, 32'd0, -32'sd9);
        send_fields(OP_SUB, 32'd6, 32'd8, 32'd3, 32'd4);          // zero result
        send_fields(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        // Random: mostly valid denominators so the arithmetic path is reached.
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            w.operation     = 3'($urandom_range(0, 7));
            w.a_numerator   = draw_value();
            w.b_numerator   = draw_value();
            n = draw_value();
            w.a_denominator = (n == 0 && $urandom_range(0, 7) != 0) ? 32'd1 : n;
            n = draw_value();
            w.b_denominator = (n == 0 && $urandom_range(0, 7) != 0) ? 32'd1 : n;
            if ($urandom_range(0, 9) == 0)
                w.b_numerator = w.a_numerator;
            send_word(w);
        end

        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
